// ----- rtl/core/rbts_pkg.sv -----
// rbts_pkg: shared widths, register indexes, action codes and the trade request type
// for the rolling band trade signal block. No dependencies.
`timescale 1ns / 1ps

package rbts_pkg;

  // fixed field widths
  localparam int WLEN_W     = 7;
  localparam int LIMIT_W    = 10;
  localparam int BAND_W     = 16;
  localparam int BW2_W      = 2 * BAND_W;
  localparam int POS_W      = 11;
  localparam int CASH_W     = 48;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIGIT_W    = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH     = 2'd2;

  // register reset values
  localparam logic [WLEN_W-1:0]  WLEN_RST  = 7'd14;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 10'd5;
  localparam logic [BAND_W-1:0]  BAND_RST  = 16'd768;

  // action codes
  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BUY     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SELL    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_BLOCKED = 2'd3;

  typedef struct packed {
    logic go;
    logic buy_hit;
    logic sell_hit;
  } trade_req_t;

endpackage

// ----- rtl/core/rbts_in_if.sv -----
// rbts_in_if: price channel, one price per word.
// Depends on nothing but its own width parameter.
`timescale 1ns / 1ps

interface rbts_in_if #(
  parameter int PRICE_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

// ----- rtl/core/rbts_out_if.sv -----
// rbts_out_if: result channel, one trade result per word.
// Depends on rbts_pkg for the field widths.
`timescale 1ns / 1ps

interface rbts_out_if ();
  import rbts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [POS_W-1:0]  net_position;
  logic signed [CASH_W-1:0] cash_balance;
  logic signed [CASH_W-1:0] marked_value;

  modport source (output valid, output action, output net_position, output cash_balance,
                  output marked_value, input ready);
  modport sink   (input valid, input action, input net_position, input cash_balance,
                  input marked_value, output ready);
endinterface

// ----- rtl/core/rbts_ring.sv -----
// rbts_ring: price ring, one write port and one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rbts_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/rbts_mul.sv -----
// rbts_mul: shared iterative multiplier, one 16-bit digit of y per cycle, msb first.
// Depends on rbts_pkg for the digit width.
`timescale 1ns / 1ps

module rbts_mul #(
  parameter int XW = 62,
  parameter int YW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [XW-1:0]      x,
  input  logic [YW-1:0]      y,
  output logic [XW+YW-1:0]   prod,
  output logic               done
);
  import rbts_pkg::*;

  localparam int NDIG  = (YW + DIGIT_W - 1) / DIGIT_W;
  localparam int YPW   = NDIG * DIGIT_W;
  localparam int PW    = XW + YW;
  localparam int CNT_W = $clog2(NDIG + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [XW-1:0]    xr;
  logic [YPW-1:0]   yr;
  logic [PW-1:0]    acc;
  logic [XW+DIGIT_W-1:0] part;

  assign part = xr * yr[YPW-1 -: DIGIT_W];
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NDIG);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= x;
      yr  <= YPW'(y);
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << DIGIT_W) + PW'(part);
      yr  <= yr << DIGIT_W;
    end
  end

endmodule

// ----- rtl/core/rbts_trade.sv -----
// rbts_trade: position and cash update, marked value and the result register.
// Depends on rbts_pkg and rbts_out_if.
`timescale 1ns / 1ps

module rbts_trade #(
  parameter int PRICE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rbts_pkg::trade_req_t          req,
  input  logic [PRICE_BITS-1:0]         price,
  input  logic [rbts_pkg::LIMIT_W-1:0]  limit,
  output logic                          ready,
  rbts_out_if.source                    result_out
);
  import rbts_pkg::*;

  localparam int PROD_W = POS_W + PRICE_BITS + 1;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_MUL  = 2'd1;
  localparam logic [1:0] T_OUT  = 2'd2;

  logic [1:0]                tstate;
  logic signed [POS_W-1:0]   held;
  logic [CASH_W-1:0]         cash;
  logic [ACT_W-1:0]          act;
  logic [PRICE_BITS-1:0]     price_t;
  logic signed [PROD_W-1:0]  prod;
  logic signed [POS_W-1:0]   lim;
  logic signed [POS_W-1:0]   neg_lim;
  logic                      out_valid;
  logic                      load;

  assign lim     = $signed({1'b0, limit});
  assign neg_lim = -lim;
  assign ready   = (tstate == T_IDLE);
  assign load    = (tstate == T_OUT) && (!out_valid || result_out.ready);

  assign result_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate    <= T_IDLE;
      held      <= '0;
      cash      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new word may replace the one leaving on this edge
      if (load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (tstate)
        T_IDLE: begin
          if (req.go) begin
            tstate <= T_MUL;
            if (req.buy_hit) begin
              if (held < lim) begin
                held <= held + POS_W'(1);
                cash <= cash - CASH_W'(price);
              end
            end else if (req.sell_hit) begin
              if (held > neg_lim) begin
                held <= held - POS_W'(1);
                cash <= cash + CASH_W'(price);
              end
            end
          end
        end
        T_MUL: tstate <= T_OUT;
        T_OUT: begin
          if (load) begin
            tstate <= T_IDLE;
          end
        end
        default: tstate <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tstate == T_IDLE && req.go) begin
      price_t <= price;
      if (req.buy_hit) begin
        act <= (held >= lim) ? ACT_BLOCKED : ACT_BUY;
      end else if (req.sell_hit) begin
        act <= (held <= neg_lim) ? ACT_BLOCKED : ACT_SELL;
      end else begin
        act <= ACT_NONE;
      end
    end
    if (tstate == T_MUL) begin
      prod <= held * $signed({1'b0, price_t});
    end
    if (load) begin
      result_out.action       <= act;
      result_out.net_position <= held;
      result_out.cash_balance <= cash;
      result_out.marked_value <= cash + CASH_W'(prod);
    end
  end

endmodule

// ----- rtl/core/rolling_band_trade_signal_top.sv -----
// rolling_band_trade_signal_top: window bookkeeping, band test sequencer, config registers.
// Depends on rbts_pkg, rbts_in_if, rbts_out_if, rbts_ring, rbts_mul and rbts_trade.
//
//   channel     dir  word / fields                                   handshake
//   price_in    in   price                                           valid/ready
//   result_out  out  action, net_position, cash_balance, marked_value valid/ready
//   cfg         in   cfg_index, cfg_data                              cfg_write strobe
//
// One shared multiplier does the window and band products, one 16-bit digit per cycle
// (NDIG digits each); band^2 and the trade unit's marked value have their own multipliers.
// A price while the window fills needs one product, the one that completes it six, and
// with a full window seven: the square of the leaving price as well.
// rst is synchronous. The ring is not cleared: the fill count means no unwritten entry is read.
// A waiting result word holds the next result in the trade unit; the price after that waits
// in its decision step, and no further price is taken until the result word drains.
`timescale 1ns / 1ps

module rolling_band_trade_signal_top #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  rbts_in_if.sink                          price_in,
  rbts_out_if.source                       result_out,
  input  logic                             cfg_write,
  input  logic [rbts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rbts_pkg::*;

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = PRICE_BITS + LEN_W;
  localparam int SQ_W  = 2 * PRICE_BITS + LEN_W;
  localparam int PSQ_W = 2 * PRICE_BITS;
  localparam int DEV_W = SQ_W + LEN_W;
  localparam int XW    = DEV_W;
  localparam int YW    = (SUM_W > BW2_W) ? SUM_W : BW2_W;
  localparam int PW    = XW + YW;
  localparam int CMP_W = BW2_W + DEV_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;

  localparam logic [2:0] OP_PSQ = 3'd0;  // price squared
  localparam logic [2:0] OP_OSQ = 3'd1;  // leaving price squared
  localparam logic [2:0] OP_LP  = 3'd2;  // L * price
  localparam logic [2:0] OP_LQ  = 3'd3;  // L * square sum
  localparam logic [2:0] OP_SS  = 3'd4;  // sum squared
  localparam logic [2:0] OP_MM  = 3'd5;  // |d| squared
  localparam logic [2:0] OP_BD  = 3'd6;  // band^2 * D

  logic [2:0]            state;
  logic [2:0]            op;
  logic [WLEN_W-1:0]     window_len;
  logic [LIMIT_W-1:0]    position_limit;
  logic [BAND_W-1:0]     band_width;
  logic [IDX_W-1:0]      ptr;
  logic [LEN_W-1:0]      fill;
  logic [SUM_W-1:0]      sum;
  logic [SQ_W-1:0]       sq;

  logic [PRICE_BITS-1:0] price_r;
  logic [BW2_W-1:0]      bw_sq;
  logic [PSQ_W-1:0]      psq_r;
  logic [PSQ_W-1:0]      osq_r;
  logic signed [SUM_W:0] d_r;
  logic [DEV_W-1:0]      lq_r;
  logic [DEV_W-1:0]      dev_r;
  logic [2*SUM_W-1:0]    m2_r;
  logic [CMP_W-1:0]      rhs_r;

  logic                  accept;
  logic [LEN_W-1:0]      len;
  logic [IDX_W-1:0]      ptr_eff;
  logic [LEN_W-1:0]      ptr_inc;
  logic [IDX_W-1:0]      ptr_next;
  logic [LEN_W-1:0]      fill_inc;
  logic                  full;
  logic                  due;
  logic [SUM_W-1:0]      sum_new;
  logic [SQ_W-1:0]       sq_new;
  logic [PRICE_BITS-1:0] old;
  logic signed [SUM_W:0] neg_d;
  logic                  d_neg;
  logic [SUM_W-1:0]      mag;
  logic                  hit;

  logic                  mul_start;
  logic [XW-1:0]         mul_x;
  logic [YW-1:0]         mul_y;
  logic [PW-1:0]         mul_prod;
  logic                  mul_done;

  trade_req_t            req;
  logic                  trade_ready;

  assign accept         = price_in.valid && price_in.ready;
  assign price_in.ready = (state == S_IDLE);

  // effective window: zero reads as one, anything beyond the ring as the ring depth
  always_comb begin
    if (window_len == '0) begin
      len = LEN_W'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(window_len);
    end
  end

  assign ptr_eff  = (LEN_W'(ptr) >= len) ? '0 : ptr;
  assign ptr_inc  = LEN_W'(ptr_eff) + LEN_W'(1);
  assign ptr_next = (ptr_inc >= len) ? '0 : ptr_inc[IDX_W-1:0];
  assign full     = (fill >= len);
  assign fill_inc = fill + LEN_W'(1);
  assign due      = full || (fill_inc >= len);

  assign sum_new = sum - (full ? SUM_W'(old) : '0) + SUM_W'(price_r);
  assign sq_new  = sq - (full ? SQ_W'(osq_r) : '0) + SQ_W'(psq_r);

  assign d_neg = d_r[SUM_W];
  assign neg_d = -d_r;
  assign mag   = d_neg ? neg_d[SUM_W-1:0] : d_r[SUM_W-1:0];
  assign hit   = (CMP_W'({m2_r, {BAND_W{1'b0}}}) >= rhs_r);

  rbts_ring #(
    .DEPTH (MAX_WINDOW),
    .AW    (IDX_W),
    .DW    (PRICE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_UPD),
    .waddr (ptr_eff),
    .wdata (price_r),
    .re    (accept),
    .raddr (ptr_eff),
    .rdata (old)
  );

  assign mul_start = (state == S_MUL);

  always_comb begin
    unique case (op)
      OP_PSQ: begin
        mul_x = XW'(price_r);
        mul_y = YW'(price_r);
      end
      OP_OSQ: begin
        mul_x = XW'(old);
        mul_y = YW'(old);
      end
      OP_LP: begin
        mul_x = XW'(price_r);
        mul_y = YW'(len);
      end
      OP_LQ: begin
        mul_x = XW'(sq);
        mul_y = YW'(len);
      end
      OP_SS: begin
        mul_x = XW'(sum);
        mul_y = YW'(sum);
      end
      OP_MM: begin
        mul_x = XW'(mag);
        mul_y = YW'(mag);
      end
      OP_BD: begin
        mul_x = XW'(dev_r);
        mul_y = YW'(bw_sq);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  rbts_mul #(
    .XW (XW),
    .YW (YW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  // zero band with d at zero passes the band test; d at zero is not negative, so buy wins
  always_comb begin
    req.go       = (state == S_DEC) && trade_ready;
    req.buy_hit  = !d_neg && hit;
    req.sell_hit = d_neg && hit;
  end

  rbts_trade #(
    .PRICE_BITS (PRICE_BITS)
  ) u_trade (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .price      (price_r),
    .limit      (position_limit),
    .ready      (trade_ready),
    .result_out (result_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= OP_PSQ;
      window_len     <= WLEN_RST;
      position_limit <= LIMIT_RST;
      band_width     <= BAND_RST;
      ptr            <= '0;
      fill           <= '0;
      sum            <= '0;
      sq             <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= OP_PSQ;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            unique case (op)
              OP_PSQ: begin
                if (full) begin
                  op    <= OP_OSQ;
                  state <= S_MUL;
                end else begin
                  state <= S_UPD;
                end
              end
              OP_OSQ: state <= S_UPD;
              OP_LP: begin
                op    <= OP_LQ;
                state <= S_MUL;
              end
              OP_LQ: begin
                op    <= OP_SS;
                state <= S_MUL;
              end
              OP_SS: begin
                op    <= OP_MM;
                state <= S_MUL;
              end
              OP_MM: begin
                op    <= OP_BD;
                state <= S_MUL;
              end
              OP_BD: state <= S_DEC;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_UPD: begin
          sum <= sum_new;
          sq  <= sq_new;
          ptr <= ptr_next;
          if (!full) begin
            fill <= fill_inc;
          end
          if (due) begin
            op    <= OP_LP;
            state <= S_MUL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DEC: begin
          if (trade_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_write) begin
        unique case (cfg_index)
          REG_WINDOW_LEN: begin
            // new length restarts the window; position and cash stay
            window_len <= cfg_data[WLEN_W-1:0];
            ptr        <= '0;
            fill       <= '0;
            sum        <= '0;
            sq         <= '0;
          end
          REG_POSITION_LIMIT: position_limit <= cfg_data[LIMIT_W-1:0];
          REG_BAND_WIDTH:     band_width     <= cfg_data[BAND_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    bw_sq <= BW2_W'(band_width) * BW2_W'(band_width);
    if (accept) begin
      price_r <= price_in.price;
    end
    if (state == S_WAIT && mul_done) begin
      case (op)
        OP_PSQ: psq_r <= mul_prod[PSQ_W-1:0];
        OP_OSQ: osq_r <= mul_prod[PSQ_W-1:0];
        OP_LP:  d_r   <= $signed({1'b0, mul_prod[SUM_W-1:0]}) - $signed({1'b0, sum});
        OP_LQ:  lq_r  <= mul_prod[DEV_W-1:0];
        OP_SS:  dev_r <= lq_r - mul_prod[DEV_W-1:0];
        OP_MM:  m2_r  <= mul_prod[2*SUM_W-1:0];
        OP_BD:  rhs_r <= mul_prod[CMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
